// ===== hw/rtl/pac_pkg.sv =====
package pac_pkg;

    localparam int TIME_BITS = 32;
    localparam int ADC_BITS  = 12;
    localparam int CUR_BITS  = 18;
    localparam int PROD_BITS = CUR_BITS + ADC_BITS;
    localparam int CFG_DATA_BITS = 18;
    localparam int CFG_INDEX_BITS = 4;

    localparam int ADC_FULL   = (1 << ADC_BITS) - 1;
    localparam int STARTUP_MA = 4000;
    localparam int BASE_MA    = 10000;
    localparam int CUR_MAX    = (1 << CUR_BITS) - 1;
    localparam int EDGE_MAX   = 15;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SAMPLE_PERIOD = 4'd0,
        CFG_NO_ROTATION   = 4'd1,
        CFG_MIN_SPEED     = 4'd2,
        CFG_PEDAL_WINDOW  = 4'd3,
        CFG_NO_PEDAL      = 4'd4,
        CFG_STARTUP       = 4'd5,
        CFG_MAX_CURRENT   = 4'd6,
        CFG_MAGNET_THR    = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]          sample_period_ms;
        logic [15:0]         no_rotation_ms;
        logic [15:0]         min_speed_period_ms;
        logic [15:0]         pedal_window_ms;
        logic [15:0]         no_pedal_ms;
        logic [15:0]         startup_ms;
        logic [CUR_BITS-1:0] max_current_ma;
        logic [3:0]          magnet_threshold;
    } cfg_t;

    typedef struct packed {
        logic motor_enable;
        logic in_startup;
        logic pedaling_flag;
        logic forward_flag;
        logic speed_ok;
    } dec_t;

endpackage

// ===== hw/rtl/pac_cfg.sv =====
module pac_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pac_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output pac_pkg::cfg_t                       cfg
);

    pac_pkg::cfg_t cfg_reg;
    pac_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pac_pkg::CFG_SAMPLE_PERIOD: cfg_next.sample_period_ms    = cfg_wdata[7:0];
                pac_pkg::CFG_NO_ROTATION:   cfg_next.no_rotation_ms      = cfg_wdata[15:0];
                pac_pkg::CFG_MIN_SPEED:     cfg_next.min_speed_period_ms = cfg_wdata[15:0];
                pac_pkg::CFG_PEDAL_WINDOW:  cfg_next.pedal_window_ms     = cfg_wdata[15:0];
                pac_pkg::CFG_NO_PEDAL:      cfg_next.no_pedal_ms         = cfg_wdata[15:0];
                pac_pkg::CFG_STARTUP:       cfg_next.startup_ms          = cfg_wdata[15:0];
                pac_pkg::CFG_MAX_CURRENT:   cfg_next.max_current_ma      = cfg_wdata[17:0];
                pac_pkg::CFG_MAGNET_THR:    cfg_next.magnet_threshold    = cfg_wdata[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period_ms    <= 8'd2;
            cfg_reg.no_rotation_ms      <= 16'd3000;
            cfg_reg.min_speed_period_ms <= 16'd1340;
            cfg_reg.pedal_window_ms     <= 16'd15000;
            cfg_reg.no_pedal_ms         <= 16'd8000;
            cfg_reg.startup_ms          <= 16'd1000;
            cfg_reg.max_current_ma      <= 18'd20000;
            cfg_reg.magnet_threshold    <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/pac_track.sv =====
module pac_track (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          wheel,
    input  logic          crank,
    input  pac_pkg::cfg_t cfg,
    output pac_pkg::dec_t dec
);

    localparam int TB = pac_pkg::TIME_BITS;

    logic [TB-1:0] time_now_reg, time_now_next;
    logic [TB-1:0] wheel_last_reg, wheel_last_next;
    logic          wheel_armed_reg, wheel_armed_next;
    logic          wheel_fast_reg, wheel_fast_next;
    logic          crank_armed_reg, crank_armed_next;
    logic [3:0]    edge_count_reg, edge_count_next;
    logic [TB-1:0] first_stroke_reg, first_stroke_next;
    logic          pedaling_reg, pedaling_next;
    logic [TB-1:0] high_begin_reg, high_begin_next;
    logic [TB-1:0] low_begin_reg, low_begin_next;
    logic [3:0]    level_flags_reg, level_flags_next;
    logic [TB-1:0] high_len_reg, high_len_next;
    logic [TB-1:0] low_len_reg, low_len_next;
    logic [TB-1:0] last_high_reg, last_high_next;
    logic [TB-1:0] last_low_reg, last_low_next;
    logic          su_phase_reg, su_phase_next;
    logic          su_started_reg, su_started_next;
    logic [TB-1:0] su_begin_reg, su_begin_next;

    logic [TB-1:0] since_wheel;
    logic [TB-1:0] since_first;
    logic [TB-1:0] level_diff;
    logic [TB-1:0] pedal_window;
    logic          fwd_prev;
    logic          fwd;
    logic          enough;
    logic          startup_drive;

    always_comb
    begin
        time_now_next     = time_now_reg + TB'(cfg.sample_period_ms);
        wheel_last_next   = wheel_last_reg;
        wheel_armed_next  = wheel_armed_reg;
        wheel_fast_next   = wheel_fast_reg;
        crank_armed_next  = crank_armed_reg;
        edge_count_next   = edge_count_reg;
        first_stroke_next = first_stroke_reg;
        pedaling_next     = pedaling_reg;
        high_begin_next   = high_begin_reg;
        low_begin_next    = low_begin_reg;
        level_flags_next  = level_flags_reg;
        high_len_next     = high_len_reg;
        low_len_next      = low_len_reg;
        last_high_next    = last_high_reg;
        last_low_next     = last_low_reg;
        su_phase_next     = su_phase_reg;
        su_started_next   = su_started_reg;
        su_begin_next     = su_begin_reg;
        startup_drive     = 1'b0;
        fwd_prev          = low_len_reg > high_len_reg;
        pedal_window      = TB'(cfg.pedal_window_ms);

        // wheel period and stop timeout
        since_wheel = time_now_reg - wheel_last_reg;
        if (wheel && wheel_armed_reg)
        begin
            wheel_fast_next  = since_wheel < TB'(cfg.min_speed_period_ms);
            wheel_armed_next = 1'b0;
            wheel_last_next  = time_now_reg;
        end
        else if (!wheel && !wheel_armed_reg)
        begin
            wheel_armed_next = 1'b1;
        end
        else if (!wheel && (since_wheel > TB'(cfg.no_rotation_ms)))
        begin
            wheel_fast_next = 1'b0;
        end

        // crank stroke counting; the window starts at the first counted stroke
        if (edge_count_reg == 4'd0)
        begin
            since_first = '0;
        end
        else
        begin
            since_first = time_now_reg - first_stroke_reg;
        end
        enough = edge_count_reg >= cfg.magnet_threshold;
        if (crank && crank_armed_reg)
        begin
            if (edge_count_reg == 4'd0)
            begin
                first_stroke_next = time_now_reg;
            end
            if (!pedaling_reg)
            begin
                if (enough && (since_first < pedal_window))
                begin
                    pedaling_next = fwd_prev && wheel_fast_next;
                end
                else if (enough && (since_first > pedal_window))
                begin
                    edge_count_next = 4'd0;
                end
                else if (edge_count_reg < 4'(pac_pkg::EDGE_MAX))
                begin
                    edge_count_next = edge_count_reg + 4'd1;
                end
            end
            crank_armed_next = 1'b0;
        end
        else if (!crank && !crank_armed_reg)
        begin
            crank_armed_next = 1'b1;
        end

        // crank high and low durations
        if (crank)
        begin
            if (!level_flags_reg[1])
            begin
                low_len_next = time_now_reg - low_begin_reg;
            end
            if (!level_flags_reg[2])
            begin
                high_begin_next = time_now_reg;
            end
            level_flags_next = 4'b0110;
            last_high_next   = time_now_reg;
        end
        else
        begin
            if (!level_flags_reg[0])
            begin
                low_begin_next = time_now_reg;
            end
            if (!level_flags_reg[3])
            begin
                high_len_next = time_now_reg - high_begin_reg;
            end
            level_flags_next = 4'b1001;
            last_low_next    = time_now_reg;
        end

        fwd = low_len_next > high_len_next;
        if (last_high_next >= last_low_next)
        begin
            level_diff = last_high_next - last_low_next;
        end
        else
        begin
            level_diff = last_low_next - last_high_next;
        end
        if (pedaling_next && (level_diff > TB'(cfg.no_pedal_ms)))
        begin
            pedaling_next   = 1'b0;
            edge_count_next = 4'd0;
        end
        if (!fwd)
        begin
            pedaling_next = 1'b0;
        end

        // startup phase
        if (pedaling_next)
        begin
            if (su_phase_reg)
            begin
                if (!su_started_reg)
                begin
                    su_begin_next   = time_now_reg;
                    su_started_next = 1'b1;
                end
                if ((time_now_reg - su_begin_next) > TB'(cfg.startup_ms))
                begin
                    su_phase_next = 1'b0;
                end
                startup_drive = 1'b1;
            end
        end
        else
        begin
            su_started_next = 1'b0;
            su_phase_next   = 1'b1;
        end

        dec.motor_enable  = pedaling_next;
        dec.in_startup    = startup_drive;
        dec.pedaling_flag = pedaling_next;
        dec.forward_flag  = fwd;
        dec.speed_ok      = wheel_fast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg     <= '0;
            wheel_last_reg   <= '0;
            wheel_armed_reg  <= 1'b1;
            wheel_fast_reg   <= 1'b0;
            crank_armed_reg  <= 1'b1;
            edge_count_reg   <= '0;
            first_stroke_reg <= '0;
            pedaling_reg     <= 1'b0;
            high_begin_reg   <= '0;
            low_begin_reg    <= '0;
            level_flags_reg  <= '0;
            high_len_reg     <= '0;
            low_len_reg      <= '0;
            last_high_reg    <= '0;
            last_low_reg     <= '0;
            su_phase_reg     <= 1'b1;
            su_started_reg   <= 1'b0;
            su_begin_reg     <= '0;
        end
        else if (fire)
        begin
            time_now_reg     <= time_now_next;
            wheel_last_reg   <= wheel_last_next;
            wheel_armed_reg  <= wheel_armed_next;
            wheel_fast_reg   <= wheel_fast_next;
            crank_armed_reg  <= crank_armed_next;
            edge_count_reg   <= edge_count_next;
            first_stroke_reg <= first_stroke_next;
            pedaling_reg     <= pedaling_next;
            high_begin_reg   <= high_begin_next;
            low_begin_reg    <= low_begin_next;
            level_flags_reg  <= level_flags_next;
            high_len_reg     <= high_len_next;
            low_len_reg      <= low_len_next;
            last_high_reg    <= last_high_next;
            last_low_reg     <= last_low_next;
            su_phase_reg     <= su_phase_next;
            su_started_reg   <= su_started_next;
            su_begin_reg     <= su_begin_next;
        end
    end

endmodule

// ===== hw/rtl/pac_current.sv =====
module pac_current (
    input  logic [pac_pkg::PROD_BITS-1:0] prod,
    input  logic                          enable,
    input  logic                          startup,
    output logic [pac_pkg::CUR_BITS-1:0]  current
);

    localparam int RW    = pac_pkg::PROD_BITS + 2;
    localparam int A     = pac_pkg::ADC_BITS;
    localparam int NTERM = pac_pkg::PROD_BITS / pac_pkg::ADC_BITS;
    localparam int NCORR = NTERM + 1;

    logic [RW-1:0] quot;
    logic [RW-1:0] rem;
    logic [RW-1:0] total;

    // divide by 2^A-1: geometric series of shifts, then a few compare-subtract fixups
    always_comb
    begin
        quot = '0;
        for (int k = 1; k <= NTERM; k++)
        begin
            quot = quot + (RW'(prod) >> (k * A));
        end
        rem = RW'(prod) - (quot << A) + quot;
        for (int i = 0; i < NCORR; i++)
        begin
            if (rem >= RW'(pac_pkg::ADC_FULL))
            begin
                rem  = rem - RW'(pac_pkg::ADC_FULL);
                quot = quot + RW'(1);
            end
        end
        total = quot + RW'(pac_pkg::BASE_MA);
        if (!enable)
        begin
            current = '0;
        end
        else if (startup)
        begin
            current = pac_pkg::CUR_BITS'(pac_pkg::STARTUP_MA);
        end
        else if (total > RW'(pac_pkg::CUR_MAX))
        begin
            current = pac_pkg::CUR_BITS'(pac_pkg::CUR_MAX);
        end
        else
        begin
            current = total[pac_pkg::CUR_BITS-1:0];
        end
    end

endmodule

// ===== hw/rtl/pedal_assist_controller_core.sv =====
// Channel  | Handshake               | Word
// ---------+-------------------------+----------------------------------------------
// in       | in_valid / in_stall     | wheel_hall, crank_hall, throttle_raw
// out      | out_valid / out_stall   | motor_enable, motor_current_ma, in_startup,
//          |                         | pedaling_flag, forward_flag, speed_ok
// cfg      | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// One word per cycle sustained while out_stall is low; out_valid rises as the word
// enters the result register (stage 0 holds it, tracking + throttle multiply fill
// stage 1, current scaling fills the result register). The tracking state updates
// once per word. Reset (rst_n low, asynchronous) empties the pipe, loads register
// defaults and clears the tracking state. A stall on the output holds the result
// register and backs up stage by stage; empty stages keep taking words meanwhile.
module pedal_assist_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                wheel_hall,
    input  logic                                crank_hall,
    input  logic [pac_pkg::ADC_BITS-1:0]        throttle_raw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                motor_enable,
    output logic [pac_pkg::CUR_BITS-1:0]        motor_current_ma,
    output logic                                in_startup,
    output logic                                pedaling_flag,
    output logic                                forward_flag,
    output logic                                speed_ok,
    input  logic                                cfg_we,
    input  logic [pac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pac_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    pac_pkg::cfg_t cfg;
    pac_pkg::dec_t dec;

    // stage 0: input register
    logic                          s0_valid_reg, s0_valid_next;
    logic                          s0_wheel_reg;
    logic                          s0_crank_reg;
    logic [pac_pkg::ADC_BITS-1:0]  s0_thr_reg;

    // stage 1: decisions and raw throttle product
    logic                          s1_valid_reg, s1_valid_next;
    pac_pkg::dec_t                 s1_dec_reg;
    logic [pac_pkg::PROD_BITS-1:0] s1_prod_reg;
    logic [pac_pkg::PROD_BITS-1:0] prod;

    // stage 2: result register
    logic                          out_valid_reg, out_valid_next;
    pac_pkg::dec_t                 out_dec_reg;
    logic [pac_pkg::CUR_BITS-1:0]  out_cur_reg;
    logic [pac_pkg::CUR_BITS-1:0]  current;

    logic out_ready, s1_ready, s0_ready;
    logic in_fire, s0_fire, s1_fire;

    // a stage moves when the one after it has room
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;
    assign in_stall  = !s0_ready;

    assign in_fire = in_valid && s0_ready;
    assign s0_fire = s0_valid_reg && s1_ready;
    assign s1_fire = s1_valid_reg && out_ready;

    assign s0_valid_next  = in_fire || (s0_valid_reg && !s1_ready);
    assign s1_valid_next  = s0_fire || (s1_valid_reg && !out_ready);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    pac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // advance the tracking state once per word leaving stage 0
    pac_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s0_fire),
        .wheel (s0_wheel_reg),
        .crank (s0_crank_reg),
        .cfg   (cfg),
        .dec   (dec)
    );

    // throttle times max current; scaled by full-scale in the next stage
    assign prod = pac_pkg::PROD_BITS'(cfg.max_current_ma)
                * pac_pkg::PROD_BITS'(s0_thr_reg);

    pac_current u_current (
        .prod    (s1_prod_reg),
        .enable  (s1_dec_reg.motor_enable),
        .startup (s1_dec_reg.in_startup),
        .current (current)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on the stage handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_wheel_reg <= wheel_hall;
            s0_crank_reg <= crank_hall;
            s0_thr_reg   <= throttle_raw;
        end
        if (s0_fire)
        begin
            s1_dec_reg  <= dec;
            s1_prod_reg <= prod;
        end
        if (s1_fire)
        begin
            out_dec_reg <= s1_dec_reg;
            out_cur_reg <= current;
        end
    end

    assign out_valid        = out_valid_reg;
    assign motor_enable     = out_dec_reg.motor_enable;
    assign motor_current_ma = out_cur_reg;
    assign in_startup       = out_dec_reg.in_startup;
    assign pedaling_flag    = out_dec_reg.pedaling_flag;
    assign forward_flag     = out_dec_reg.forward_flag;
    assign speed_ok         = out_dec_reg.speed_ok;

`ifndef ASSERT_OFF
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_dec_reg.motor_enable |->
            out_cur_reg == '0 && !out_dec_reg.in_startup)
        else $error("released motor with nonzero current or startup");

    a_startup_current: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dec_reg.in_startup |->
            out_cur_reg == pac_pkg::CUR_BITS'(pac_pkg::STARTUP_MA))
        else $error("startup phase without startup current");

    a_drive_needs_forward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dec_reg.motor_enable |->
            out_dec_reg.pedaling_flag && out_dec_reg.forward_flag)
        else $error("motor driven without forward pedaling");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && out_stall |=> s1_valid_reg && $stable(s1_prod_reg))
        else $error("stage 1 word lost under stall");
`endif

endmodule
